// File: rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the stable min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int COST_W   = 32;
  localparam int KEY_W    = 32;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 88;

  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_REM_ONE  = 3'd3,
    CMD_REM_ALL  = 3'd4,
    CMD_CONTAINS = 3'd5,
    CMD_TRIM     = 3'd6,
    CMD_CLEAR    = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_ev;
    logic push_rd;
    logic push_ev;
    logic push_place;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    cmd_t op;
    logic invalid;
    logic full;
    logic empty;
    logic scan_last;
    logic pos_zero;
    logic push_gt;
  } stat_t;

endpackage

// File: rtl/smpq_ctrl.sv
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer for the queue: accepts a command, steps the datapath through the
// store and releases one result transaction.
// ----------------------------------------------------------------------------
module smpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  smpq_pkg::stat_t st,
  output smpq_pkg::ctrl_t ctl
);
  import smpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_SRD, S_SEV, S_PRD, S_PEV, S_FIN
  } state_t;

  state_t state, state_next;
  logic   fin_go;

  assign in_ready = (state == S_IDLE);
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          CMD_PUSH:     state_next = (st.invalid || st.full) ? S_FIN : S_PRD;
          CMD_REM_ONE:  state_next = (st.invalid || st.empty) ? S_FIN : S_SRD;
          CMD_POP, CMD_PEEK, CMD_REM_ALL, CMD_CONTAINS:
                        state_next = st.empty ? S_FIN : S_SRD;
          default:      state_next = S_FIN;
        endcase
      end
      S_SRD: begin
        ctl.scan_rd = 1'b1;
        state_next  = S_SEV;
      end
      S_SEV: begin
        ctl.scan_ev = 1'b1;
        state_next  = (st.scan_last || st.op == CMD_PEEK) ? S_FIN : S_SRD;
      end
      S_PRD: begin
        if (st.pos_zero) begin
          ctl.push_place = 1'b1;
          state_next     = S_FIN;
        end else begin
          ctl.push_rd = 1'b1;
          state_next  = S_PEV;
        end
      end
      S_PEV: begin
        if (st.push_gt) begin
          ctl.push_ev = 1'b1;
          state_next  = S_PRD;
        end else begin
          ctl.push_place = 1'b1;
          state_next     = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/smpq_dp.sv
// ----------------------------------------------------------------------------
// smpq_dp
// Datapath for the queue: sorted entry store, scan and insert indexes,
// occupancy and the result register.
// ----------------------------------------------------------------------------
module smpq_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2:0]                  in_cmd,
  input  logic [smpq_pkg::IN_W-1:0]   in_data,
  input  smpq_pkg::ctrl_t             ctl,
  output smpq_pkg::stat_t             st,
  output logic [smpq_pkg::OUT_W-1:0]  out_data
);
  import smpq_pkg::*;

  logic [COST_W+KEY_W-1:0] mem [CAPACITY];
  logic [COST_W+KEY_W-1:0] rd_q;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [COST_W+KEY_W-1:0] wr_data;

  cmd_t              op;
  logic [COST_W-1:0] canon;
  logic [KEY_W-1:0]  key;
  logic [CNT_W-1:0]  limit;
  logic              invalid;
  logic [CNT_W-1:0]  count, idx, wpos, pos, removed;
  logic              hit;
  logic [COST_W-1:0] res_cost;
  logic [KEY_W-1:0]  res_key;

  logic [COST_W-1:0] in_cost;
  logic [COST_W-1:0] rd_cost;
  logic [KEY_W-1:0]  rd_key;
  logic              drop;
  logic [CNT_W-1:0]  pos_m1;

  logic [1:0]        f_status;
  logic [CNT_W-1:0]  f_removed, f_count;

  assign in_cost = in_data[COST_W-1:0];
  assign rd_cost = rd_q[COST_W+KEY_W-1:KEY_W];
  assign rd_key  = rd_q[KEY_W-1:0];
  assign pos_m1  = pos - CNT_W'(1);

  assign st.op        = op;
  assign st.invalid   = invalid;
  assign st.full      = (count == CNT_W'(CAPACITY));
  assign st.empty     = (count == '0);
  assign st.scan_last = ((idx + CNT_W'(1)) == count);
  assign st.pos_zero  = (pos == '0);
  assign st.push_gt   = (rd_cost > canon);

  always_comb begin
    drop = 1'b0;
    case (op)
      CMD_POP:     drop = (idx == '0);
      CMD_REM_ONE: drop = !hit && (rd_cost == canon) && (rd_key == key);
      CMD_REM_ALL: drop = (rd_key == key);
      default:     drop = 1'b0;
    endcase
  end

  assign rd_addr = ctl.push_rd ? pos_m1[ADDR_W-1:0] : idx[ADDR_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wpos[ADDR_W-1:0];
    wr_data = rd_q;
    if (ctl.scan_ev && !drop) begin
      wr_en = 1'b1;
    end else if (ctl.push_ev) begin
      wr_en   = 1'b1;
      wr_addr = pos[ADDR_W-1:0];
    end else if (ctl.push_place) begin
      wr_en   = 1'b1;
      wr_addr = pos[ADDR_W-1:0];
      wr_data = {canon, key};
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    f_status  = ST_OK;
    f_removed = '0;
    f_count   = count;
    case (op)
      CMD_PUSH: begin
        if (invalid) begin
          f_status = ST_INVALID;
        end else if (st.full) begin
          f_status = ST_FULL;
        end else begin
          f_count = count + CNT_W'(1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (st.empty) begin
          f_status = ST_EMPTY;
        end
        f_count = count - removed;
      end
      CMD_REM_ONE: begin
        if (invalid) begin
          f_status = ST_INVALID;
        end
        f_count = count - removed;
      end
      CMD_REM_ALL: begin
        f_removed = removed;
        f_count   = count - removed;
      end
      CMD_TRIM: begin
        if (count > limit) begin
          f_removed = count - limit;
          f_count   = limit;
        end
      end
      CMD_CLEAR: f_count = '0;
      default:   f_count = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (ctl.load) begin
        op      <= cmd_t'(in_cmd);
        canon   <= (in_cost == 32'h8000_0000) ? '0 : in_cost;
        invalid <= (in_cost != 32'h8000_0000) &&
                   (in_cost[31] || (in_cost[30:23] == 8'hFF));
        key     <= in_data[COST_W+KEY_W-1:COST_W];
        limit   <= in_data[COST_W+KEY_W+CNT_W-1:COST_W+KEY_W];
        idx      <= '0;
        wpos     <= '0;
        pos      <= count;
        removed  <= '0;
        hit      <= 1'b0;
        res_cost <= '0;
        res_key  <= '0;
      end
      if (ctl.scan_ev) begin
        idx <= idx + CNT_W'(1);
        if (drop) begin
          removed <= removed + CNT_W'(1);
        end else begin
          wpos <= wpos + CNT_W'(1);
        end
        if ((op == CMD_REM_ONE && drop) || (op == CMD_CONTAINS && rd_key == key)) begin
          hit <= 1'b1;
        end
        if ((op == CMD_POP || op == CMD_PEEK) && idx == '0) begin
          res_cost <= rd_cost;
          res_key  <= rd_key;
        end
      end
      if (ctl.push_ev) begin
        pos <= pos_m1;
      end
      if (ctl.finish) begin
        count    <= f_count;
        out_data <= {3'b000, f_count, hit, f_removed, res_key, res_cost, f_status};
      end
    end
  end

endmodule

// File: rtl/stable_min_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue_top
// Bounded min-priority queue of cost and coordinate entries, kept in cost
// order with equal costs in insertion order.
// ----------------------------------------------------------------------------
// Each command gives one result transaction. Trim, clear, rejected commands
// and commands on an empty store go straight to the result; peek reads only
// the front entry. Push moves each held entry with a larger cost back by one
// place, from the back of the store, before it writes the new entry. Pop,
// remove_one, remove_all and contains walk the whole store. The entry memory
// has one read and one write port and moves one entry at a time (read, then
// compare and write back).
module stable_min_priority_queue_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // cost_bits[31:0], coord_key[63:32], size_limit[72:64], zero fill
  input  logic [smpq_pkg::IN_W-1:0]   s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], out_cost_bits[33:2], out_coord_key[65:34],
  // removed_count[74:66], hit[75], occupancy[84:76], zero fill
  output logic [smpq_pkg::OUT_W-1:0]  m_axis_tdata
);
  import smpq_pkg::*;

  ctrl_t ctl;
  stat_t st;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .ctl       (ctl)
  );

  smpq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .ctl      (ctl),
    .st       (st),
    .out_data (m_axis_tdata)
  );

endmodule

// File: verif/stable_min_priority_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_checker
// Watches both stream channels of the priority queue, keeps its own sorted
// store of cost and key entries, predicts each result transaction and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [smpq_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic [2:0]                 s_axis_tuser,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [smpq_pkg::OUT_W-1:0] m_axis_tdata,
  output int                         fail_count,
  output int                         pending
);
  import smpq_pkg::*;

  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [8:0]  occupancy;
    logic        hit;
    logic [8:0]  removed_count;
    logic [31:0] out_coord_key;
    logic [31:0] out_cost_bits;
    logic [1:0]  status;
  } result_t;

  logic [31:0] q_cost [CAPACITY];
  logic [31:0] q_key  [CAPACITY];
  int          q_count;
  result_t     exp_fifo [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;

  assign pending = exp_wr - exp_rd;

  function automatic bit cost_ok(input logic [31:0] bits, output logic [31:0] canon);
    canon = bits;
    if (bits == 32'h8000_0000) begin
      canon = '0;
      return 1'b1;
    end
    if (bits[31]) return 1'b0;
    if (bits[30:23] == 8'hFF) return 1'b0;
    return 1'b1;
  endfunction

  task automatic drop_at(input int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_cost[i] = q_cost[i+1];
      q_key[i]  = q_key[i+1];
    end
    q_count--;
  endtask

  task automatic predict_queue(input cmd_t op, input logic [31:0] cost,
                               input logic [31:0] key, input logic [8:0] limit);
    result_t     r;
    logic [31:0] canon;
    int          pos;
    int          j;
    r = '0;
    case (op)
      CMD_PUSH: begin
        if (!cost_ok(cost, canon)) r.status = ST_INVALID;
        else if (q_count >= CAPACITY) r.status = ST_FULL;
        else begin
          pos = q_count;
          while (pos > 0 && q_cost[pos-1] > canon) begin
            q_cost[pos] = q_cost[pos-1];
            q_key[pos]  = q_key[pos-1];
            pos--;
          end
          q_cost[pos] = canon;
          q_key[pos]  = key;
          q_count++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (q_count == 0) r.status = ST_EMPTY;
        else begin
          r.out_cost_bits = q_cost[0];
          r.out_coord_key = q_key[0];
          if (op == CMD_POP) drop_at(0);
        end
      end
      CMD_REM_ONE: begin
        if (!cost_ok(cost, canon)) r.status = ST_INVALID;
        else begin
          for (int i = 0; i < q_count; i++) begin
            if (q_cost[i] == canon && q_key[i] == key) begin
              drop_at(i);
              r.hit = 1'b1;
              break;
            end
          end
        end
      end
      CMD_REM_ALL: begin
        j = 0;
        for (int i = 0; i < q_count; i++) begin
          if (q_key[i] == key) r.removed_count++;
          else begin
            q_cost[j] = q_cost[i];
            q_key[j]  = q_key[i];
            j++;
          end
        end
        q_count = j;
      end
      CMD_CONTAINS: begin
        for (int i = 0; i < q_count; i++) begin
          if (q_key[i] == key) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      CMD_TRIM: begin
        if (q_count > int'(limit)) begin
          r.removed_count = 9'(q_count - int'(limit));
          q_count = int'(limit);
        end
      end
      default: q_count = 0;
    endcase
    r.occupancy = 9'(q_count);
    if (exp_wr - exp_rd >= EXP_DEPTH) begin
      fail_count++;
      if (fail_count <= 10) $display("too many outstanding transactions");
    end else begin
      exp_fifo[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      q_count = 0;
      fail_count = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (exp_wr == exp_rd) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: st %0d/%0d cost %h/%h key %h/%h rem %0d/%0d hit %0d/%0d occ %0d/%0d",
                       want.status, got.status, want.out_cost_bits, got.out_cost_bits,
                       want.out_coord_key, got.out_coord_key, want.removed_count,
                       got.removed_count, want.hit, got.hit, want.occupancy, got.occupancy);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_queue(cmd_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32],
                      s_axis_tdata[72:64]);
    end
  end

endmodule

// File: verif/stable_min_priority_queue_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_top_test
// Drives directed and random command transactions into the priority queue,
// with random idling on both channels and one long receiver hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_top_test;
  import smpq_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic [2:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  int                fail_count;
  int                pending;
  bit                calm = 1'b0;
  bit                hold_off = 1'b0;
  int                sent = 0;
  logic [31:0]       key_pool [8];
  logic [31:0]       cost_pool [8];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stable_min_priority_queue_top u_dut (.*);

  stable_min_priority_queue_checker u_checker (.*);

  task automatic send_cmd(input cmd_t op, input logic [31:0] cost,
                          input logic [31:0] key, input logic [8:0] limit);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, limit, key, cost};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return {1'b1, 31'($urandom)};
      1: return {1'b0, 8'hFF, 23'($urandom_range(0, 3))};
      2: return 32'h8000_0000;
      3, 4, 5: return cost_pool[$urandom_range(0, 7)];
      default: return {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    for (int i = 0; i < 8; i++) begin
      key_pool[i]  = $urandom;
      cost_pool[i] = {1'b0, 8'($urandom_range(100, 140)), 23'($urandom_range(0, 3))};
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_cmd(CMD_POP, '0, '0, '0);
    send_cmd(CMD_PEEK, '0, '0, '0);
    send_cmd(CMD_PUSH, 32'h8000_0000, '1, '0);
    send_cmd(CMD_PUSH, 32'h7F7F_FFFF, '0, '1);
    send_cmd(CMD_PUSH, 32'h7F80_0000, 32'h5, '0);
    send_cmd(CMD_PUSH, 32'h7FC0_0001, 32'h5, '0);
    send_cmd(CMD_PUSH, 32'hBF80_0000, 32'h5, '0);
    send_cmd(CMD_PUSH, 32'h3F80_0000, 32'h7, '0);
    send_cmd(CMD_PUSH, 32'h3F80_0000, 32'h8, '0);
    send_cmd(CMD_PUSH, 32'h0000_0001, 32'h7, '0);
    send_cmd(CMD_PEEK, '0, '0, '0);
    send_cmd(CMD_CONTAINS, '0, 32'h8, '0);
    send_cmd(CMD_CONTAINS, '0, 32'h9, '0);
    send_cmd(CMD_REM_ONE, 32'h3F80_0000, 32'h9, '0);
    send_cmd(CMD_REM_ONE, 32'hFF80_0000, 32'h7, '0);
    send_cmd(CMD_REM_ONE, 32'h3F80_0000, 32'h8, '0);
    send_cmd(CMD_REM_ALL, '0, 32'h7, '0);
    send_cmd(CMD_TRIM, '0, '0, 9'd256);
    send_cmd(CMD_TRIM, '0, '0, 9'd0);
    send_cmd(CMD_PUSH, 32'h0, 32'h1, '0);
    send_cmd(CMD_CLEAR, '1, '1, '1);
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 40) hold_off = 1'b1;
      send_cmd(CMD_PUSH, {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)}, pick_key(), '0);
    end
    send_cmd(CMD_PUSH, 32'h3F00_0000, '1, '0);
    send_cmd(CMD_POP, '0, '0, '0);
    for (int i = 0; i < 1200; i++) begin
      if (i == 1000) calm = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: send_cmd(CMD_PUSH, pick_cost(), pick_key(), 9'($urandom));
        7, 8: send_cmd(CMD_POP, $urandom, $urandom, 9'($urandom));
        9: send_cmd(CMD_PEEK, $urandom, $urandom, 9'($urandom));
        10, 11: send_cmd(CMD_REM_ONE, pick_cost(), pick_key(), 9'($urandom));
        12: send_cmd(CMD_REM_ALL, $urandom, pick_key(), 9'($urandom));
        13, 14: send_cmd(CMD_CONTAINS, $urandom, pick_key(), 9'($urandom));
        15: send_cmd(CMD_TRIM, $urandom, $urandom, 9'($urandom_range(0, 40)));
        16: send_cmd(CMD_TRIM, $urandom, $urandom, 9'($urandom));
        17: if ($urandom_range(0, 5) == 0) send_cmd(CMD_CLEAR, $urandom, $urandom, 9'($urandom));
        default: send_cmd(CMD_PEEK, '0, '0, '0);
      endcase
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("stable_min_priority_queue_top_test passed");
    end else begin
      $display("stable_min_priority_queue_top_test failed");
    end
    $finish;
  end

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (2000) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #40_000_000;
    $display("stable_min_priority_queue_top_test failed");
    $finish;
  end

endmodule
